>>> design/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

  // Field widths of the channels and the configuration port
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int COL_IN_W = 7;
  localparam int ROW_IN_W = 5;
  localparam int OFFS_W = 11;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  // Character codes with special meaning
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_TAB_MOD,
    ST_TAB_NORM,
    ST_SCROLL_COPY,
    ST_SCROLL_DRAIN,
    ST_FILL,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic write_char;
    logic newline;
    logic set_cursor;
    logic capture_cell;
    logic mod_start;
    logic mod_step;
    logic tab_apply;
    logic norm_step;
    logic copy_step;
    logic fill_start_all;
    logic fill_start_bottom;
    logic fill_step;
    logic result_load;
  } tcw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_write;
    logic is_set;
    logic is_clear;
    logic is_read;
    logic is_newline;
    logic is_tab;
    logic at_last_col;
    logic at_last_row;
    logic mod_done;
    logic col_over;
    logic pos_over;
    logic copy_last;
    logic fill_last;
  } tcw_status_t;

endpackage

>>> design/tcw_if.sv
// Valid/ready channel interfaces for the request and result beats.
interface tcw_in_if;
  import tcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CHAR_W-1:0]   char_code;
  logic [COL_IN_W-1:0] column;
  logic [ROW_IN_W-1:0] row;

  modport source (output valid, func, char_code, column, row, input ready);
  modport sink (input valid, func, char_code, column, row, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFFS_W-1:0]   cursor_offset;
  logic [COL_IN_W-1:0] cursor_column;
  logic [ROW_IN_W-1:0] cursor_row;
  logic [CHAR_W-1:0]   cell_char;
  logic [ATTR_W-1:0]   cell_attr;

  modport source (output valid, cursor_offset, cursor_column, cursor_row, cell_char,
                  cell_attr, input ready);
  modport sink (input valid, cursor_offset, cursor_column, cursor_row, cell_char,
                cell_attr, output ready);
endinterface

>>> design/tcw_dpath.sv
// Datapath: screen memory, cursor registers, tab remainder unit and result register.
module tcw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata_i,
  input  logic [tcw_pkg::FUNC_W-1:0]    func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::COL_IN_W-1:0]  column_i,
  input  logic [tcw_pkg::ROW_IN_W-1:0]  row_i,
  input  tcw_pkg::tcw_cmd_t             cmd_i,
  output tcw_pkg::tcw_status_t          status_o,
  output logic [tcw_pkg::OFFS_W-1:0]    cursor_offset_o,
  output logic [tcw_pkg::COL_IN_W-1:0]  cursor_column_o,
  output logic [tcw_pkg::ROW_IN_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::CHAR_W-1:0]    cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]    cell_attr_o
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W = $clog2(CELLS + COLUMNS + TAB_STOP);
  localparam int COL_W = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W = $clog2(ROWS + 2);
  localparam int CNT_W = 1;
  // Reciprocal of the tab stop, exact for every offset below 2**POS_W
  localparam int TAB_L = $clog2(TAB_STOP);
  localparam int RCP_SH = POS_W + TAB_L;
  localparam int RCP = ((1 << RCP_SH) + TAB_STOP - 1) / TAB_STOP;
  localparam int PROD_W = 2 * POS_W + 1;

  // Configuration and latched request
  logic [ATTR_W-1:0]   attr_q;
  logic [FUNC_W-1:0]   func_q;
  logic [CHAR_W-1:0]   char_q;
  logic [COL_IN_W-1:0] col_in_q;
  logic [ROW_IN_W-1:0] row_in_q;

  // Cursor
  logic [POS_W-1:0] pos_q, pos_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Tab remainder unit
  logic [POS_W-1:0]  rem_q;
  logic [POS_W-1:0]  quot_q;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  mcnt_q;
  logic [POS_W-1:0]  tab_delta;

  // Sweep counter, copy pipeline and memory ports
  logic [ADDR_W-1:0] idx_q;
  logic              blank_q;
  logic              pend_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] rdata_q;
  logic [CELL_W-1:0] cell_mem [CELLS];
  logic [CELL_W-1:0] cell_q;

  // Clamped request position
  logic [COL_W-1:0] col_c;
  logic [ROW_W-1:0] row_c;
  logic [POS_W-1:0] addr_c;

  // Hold the default attribute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // Latch the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      char_q   <= char_code_i;
      col_in_q <= column_i;
      row_in_q <= row_i;
    end
  end

  // Clamp column and row to the screen and form the linear offset
  always_comb begin
    col_c = (32'(col_in_q) > 32'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(col_in_q);
    row_c = (32'(row_in_q) > 32'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(row_in_q);
    addr_c = POS_W'(row_c) * POS_W'(COLUMNS) + POS_W'(col_c);
  end

  assign tab_delta = POS_W'(TAB_STOP) - rem_q;

  // Compute the next cursor
  always_comb begin
    pos_d = pos_q;
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.set_cursor) begin
      pos_d = addr_c;
      col_d = col_c;
      row_d = row_c;
    end else if (cmd_i.write_char) begin
      pos_d = pos_q + POS_W'(1);
      if (col_q == COL_W'(COLUMNS - 1)) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else if (cmd_i.newline) begin
      pos_d = pos_q + POS_W'(COLUMNS) - POS_W'(col_q);
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else if (cmd_i.tab_apply) begin
      pos_d = pos_q + tab_delta;
      col_d = col_q + COL_W'(tab_delta);
    end else if (cmd_i.norm_step) begin
      col_d = col_q - COL_W'(COLUMNS);
      row_d = row_q + ROW_W'(1);
    end else if (cmd_i.fill_start_all) begin
      pos_d = '0;
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.fill_start_bottom) begin
      pos_d = POS_W'(CELLS - COLUMNS);
      col_d = '0;
      row_d = ROW_W'(ROWS - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      pos_q <= pos_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Reduce the offset modulo the tab stop: quotient first, then remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (cmd_i.mod_start) begin
      mcnt_q <= CNT_W'(1);
    end else if (cmd_i.mod_step) begin
      mcnt_q <= mcnt_q - CNT_W'(1);
    end
  end

  assign prod = PROD_W'(pos_q) * PROD_W'(RCP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      quot_q <= POS_W'(prod >> RCP_SH);
    end else if (cmd_i.mod_step) begin
      rem_q <= pos_q - quot_q * POS_W'(TAB_STOP);
    end
  end

  // Advance the sweep counter for copy and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      blank_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= cmd_i.copy_step;
      if (cmd_i.fill_start_all) begin
        idx_q   <= '0;
        blank_q <= 1'b1;
      end else if (cmd_i.fill_start_bottom) begin
        idx_q   <= ADDR_W'(CELLS - COLUMNS);
        blank_q <= 1'b1;
      end else if (cmd_i.fill_step) begin
        idx_q <= status_o.fill_last ? '0 : idx_q + ADDR_W'(1);
      end else if (cmd_i.copy_step) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= idx_q;
  end

  // Select the memory write and read
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q[ADDR_W-1:0];
    mem_wdata = {attr_q, char_q};
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = rdata_q;
    end else if (cmd_i.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = idx_q;
      mem_wdata = blank_q ? {attr_q, CH_SPACE} : '0;
    end else if (cmd_i.write_char) begin
      mem_we = 1'b1;
    end
    mem_raddr = cmd_i.copy_step ? idx_q + ADDR_W'(COLUMNS) : addr_c[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= cell_mem[mem_raddr];
  end

  // Hold the cell that was read, zero for other operations
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cell_q <= '0;
    end else if (cmd_i.capture_cell) begin
      cell_q <= rdata_q;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      cursor_offset_o <= OFFS_W'(pos_q);
      cursor_column_o <= COL_IN_W'(col_q);
      cursor_row_o    <= ROW_IN_W'(row_q);
      cell_char_o     <= cell_q[CHAR_W-1:0];
      cell_attr_o     <= cell_q[CELL_W-1:CHAR_W];
    end
  end

  // Report status
  always_comb begin
    status_o.is_write    = func_e'(func_q) == FUNC_WRITE;
    status_o.is_set      = func_e'(func_q) == FUNC_SET;
    status_o.is_clear    = func_e'(func_q) == FUNC_CLEAR;
    status_o.is_read     = func_e'(func_q) == FUNC_READ;
    status_o.is_newline  = char_q == CH_NEWLINE;
    status_o.is_tab      = char_q == CH_TAB;
    status_o.at_last_col = col_q == COL_W'(COLUMNS - 1);
    status_o.at_last_row = row_q == ROW_W'(ROWS - 1);
    status_o.mod_done    = mcnt_q == '0;
    status_o.col_over    = col_q >= COL_W'(COLUMNS);
    status_o.pos_over    = pos_q >= POS_W'(CELLS);
    status_o.copy_last   = idx_q == ADDR_W'(CELLS - COLUMNS - 1);
    status_o.fill_last   = idx_q == ADDR_W'(CELLS - 1);
  end

endmodule

>>> design/tcw_ctrl.sv
// Controller: sequences each operation and owns the channel handshakes.
module tcw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  input  tcw_pkg::tcw_status_t  status_i,
  output tcw_pkg::tcw_cmd_t     cmd_o,
  output logic                  in_ready_o,
  output logic                  out_valid_o
);
  import tcw_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.fill_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (status_i.is_write) begin
          priority if (status_i.is_newline) begin
            state_d = status_i.at_last_row ? ST_SCROLL_COPY : ST_DONE;
          end else if (status_i.is_tab) begin
            state_d = ST_TAB_MOD;
          end else begin
            state_d = (status_i.at_last_col && status_i.at_last_row) ? ST_SCROLL_COPY
                                                                      : ST_DONE;
          end
        end else if (status_i.is_set) begin
          state_d = ST_DONE;
        end else if (status_i.is_clear) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_READ_WAIT;
        end
      end
      ST_READ_WAIT: state_d = ST_DONE;
      ST_TAB_MOD: begin
        if (status_i.mod_done) state_d = ST_TAB_NORM;
      end
      ST_TAB_NORM: begin
        if (!status_i.col_over) begin
          state_d = status_i.pos_over ? ST_SCROLL_COPY : ST_DONE;
        end
      end
      ST_SCROLL_COPY: begin
        if (status_i.copy_last) state_d = ST_SCROLL_DRAIN;
      end
      ST_SCROLL_DRAIN: state_d = ST_FILL;
      ST_FILL: begin
        if (status_i.fill_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_INIT: cmd_o.fill_step = 1'b1;
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_EXEC: begin
        priority if (status_i.is_write) begin
          priority if (status_i.is_newline) begin
            cmd_o.newline = 1'b1;
          end else if (status_i.is_tab) begin
            cmd_o.mod_start = 1'b1;
          end else begin
            cmd_o.write_char = 1'b1;
          end
        end else if (status_i.is_set) begin
          cmd_o.set_cursor = 1'b1;
        end else if (status_i.is_clear) begin
          cmd_o.fill_start_all = 1'b1;
        end
      end
      ST_READ_WAIT: cmd_o.capture_cell = 1'b1;
      ST_TAB_MOD: begin
        if (status_i.mod_done) begin
          cmd_o.tab_apply = 1'b1;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      ST_TAB_NORM: cmd_o.norm_step = status_i.col_over;
      ST_SCROLL_COPY: cmd_o.copy_step = 1'b1;
      ST_SCROLL_DRAIN: cmd_o.fill_start_bottom = 1'b1;
      ST_FILL: cmd_o.fill_step = 1'b1;
      ST_DONE: cmd_o.result_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_o.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

>>> design/text_console_writer.sv
// Character-cell text console: top level joining controller and datapath.
//
// Usage: requests arrive as beats on in_i (func, char_code, column, row) and
// each produces exactly one result beat on out_o with the cursor offset,
// column and row after the operation and, for a cell read, the cell's
// character and attribute. cfg_we_i/cfg_wdata_i set the default attribute
// (reset value 7); write it only while no request is in flight.
// A printed character, newline or set cursor without scroll goes from EXEC
// to DONE; a cell read passes through READ_WAIT on the way. A tab passes
// through the remainder unit (quotient, then remainder) and the column
// normalization, one normalization step for each row it wraps into. A scroll
// walks the screen memory over its single write port: a copy pass, then a
// blank fill of the bottom row; a clear fills every cell with blanks.
// The next request beat is taken in the cycle after the result is loaded, so
// no new request is taken until the last one's result is loaded.
// Reset: the cursor homes, and a clearing pass over every cell zeroes
// the screen memory with in_i.ready low. While out_o is stalled one finished
// result waits in the output register; the next request is still taken, and
// its own result waits until the first one is taken.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata_i,
  tcw_in_if.sink                      in_i,
  tcw_out_if.source                   out_o
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  tcw_dpath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (in_i.func),
    .char_code_i     (in_i.char_code),
    .column_i        (in_i.column),
    .row_i           (in_i.row),
    .cmd_i           (cmd),
    .status_o        (status),
    .cursor_offset_o (out_o.cursor_offset),
    .cursor_column_o (out_o.cursor_column),
    .cursor_row_o    (out_o.cursor_row),
    .cell_char_o     (out_o.cell_char),
    .cell_attr_o     (out_o.cell_attr)
  );

endmodule

>>> design/tcw_checker.sv
// Port-level assertions for the text console writer, bound to the top level.
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tcw_pkg::OFFS_W-1:0]    cursor_offset_i,
  input logic [tcw_pkg::COL_IN_W-1:0]  cursor_column_i,
  input logic [tcw_pkg::ROW_IN_W-1:0]  cursor_row_i,
  input logic [tcw_pkg::CHAR_W-1:0]    cell_char_i,
  input logic [tcw_pkg::ATTR_W-1:0]    cell_attr_i
);
  import tcw_pkg::*;

  // Cursor fields are exact only when the screen fits the field widths
  localparam bit FIELDS_EXACT = (COLUMNS <= 128) && (ROWS <= 32) && (COLUMNS * ROWS <= 2048);

  // One request at a time: a taken beat closes the input
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in flight");

  // Offset, column and row of a result agree
  a_cursor_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && FIELDS_EXACT |->
      (32'(cursor_column_i) < COLUMNS) && (32'(cursor_row_i) < ROWS) &&
      (cursor_offset_i == OFFS_W'(32'(cursor_row_i) * COLUMNS + 32'(cursor_column_i))))
    else $error("cursor offset does not match column and row");

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable({cursor_offset_i, cursor_column_i, cursor_row_i, cell_char_i, cell_attr_i}))
    else $error("result payload changed while stalled");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .cursor_offset_i (out_o.cursor_offset),
  .cursor_column_i (out_o.cursor_column),
  .cursor_row_i    (out_o.cursor_row),
  .cell_char_i     (out_o.cell_char),
  .cell_attr_i     (out_o.cell_attr)
);

>>> tb/text_console_writer_test.sv
// Self-checking testbench for the text console writer: directed and random requests vs. a predictor.
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int SCREEN_W = 80;
  localparam int SCREEN_H = 25;
  localparam int TAB_W = 8;
  localparam int CELL_TOTAL = SCREEN_W * SCREEN_H;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 2100;
  localparam int RANDOM_ITEMS = 540;

  // One result beat as the block reports it
  typedef struct packed {
    logic [OFFS_W-1:0]   offset;
    logic [COL_IN_W-1:0] column;
    logic [ROW_IN_W-1:0] row;
    logic [CHAR_W-1:0]   char_code;
    logic [ATTR_W-1:0]   attr;
  } console_view_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ATTR_W-1:0] cfg_wdata_i;

  tcw_in_if  req_if ();
  tcw_out_if rsp_if ();

  text_console_writer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  // Shadow of the console state
  int unsigned       caret;
  logic [CHAR_W-1:0] shadow_char [CELL_TOTAL];
  logic [ATTR_W-1:0] shadow_attr [CELL_TOTAL];
  logic [ATTR_W-1:0] attr_now;

  console_view_t expected_views [$];
  console_view_t want_view;
  console_view_t got_view;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_ack;
  int hold_left;
  int quiet_cycles;
  int error_cnt;
  int requests_sent;
  int results_checked;
  int scroll_cnt;
  int clear_cnt;
  int attr_writes;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Clamp a column and row to the screen and return the cell index
  function automatic int unsigned cell_index(logic [COL_IN_W-1:0] col, logic [ROW_IN_W-1:0] rw);
    int unsigned c;
    int unsigned r;
    c = 32'(col);
    r = 32'(rw);
    if (c > SCREEN_W - 1) c = SCREEN_W - 1;
    if (r > SCREEN_H - 1) r = SCREEN_H - 1;
    return r * SCREEN_W + c;
  endfunction

  // Blank the cells in [lo, hi) with spaces in the current attribute
  function automatic void blank_cells(int unsigned lo, int unsigned hi);
    for (int unsigned i = lo; i < hi; i++) begin
      shadow_char[i] = CH_SPACE;
      shadow_attr[i] = attr_now;
    end
  endfunction

  // Apply one request to the shadow state and return the result it produces
  function automatic console_view_t apply_request(func_e op, logic [CHAR_W-1:0] ch,
                                                  logic [COL_IN_W-1:0] col,
                                                  logic [ROW_IN_W-1:0] rw);
    console_view_t v;
    int unsigned   pos;
    int unsigned   addr;
    v = '0;
    case (op)
      FUNC_WRITE: begin
        pos = caret;
        if (pos >= CELL_TOTAL) pos = 0;
        if (ch == CH_NEWLINE) begin
          pos += SCREEN_W - pos % SCREEN_W;
        end else if (ch == CH_TAB) begin
          pos += TAB_W - pos % TAB_W;
        end else begin
          shadow_char[pos] = ch;
          shadow_attr[pos] = attr_now;
          pos++;
        end
        // Scroll up one row once the cursor runs off the end
        if (pos >= CELL_TOTAL) begin
          for (int unsigned i = 0; i < CELL_TOTAL - SCREEN_W; i++) begin
            shadow_char[i] = shadow_char[i + SCREEN_W];
            shadow_attr[i] = shadow_attr[i + SCREEN_W];
          end
          blank_cells(CELL_TOTAL - SCREEN_W, CELL_TOTAL);
          pos = CELL_TOTAL - SCREEN_W;
          scroll_cnt++;
        end
        caret = pos;
      end
      FUNC_SET: begin
        caret = cell_index(col, rw);
      end
      FUNC_CLEAR: begin
        blank_cells(0, CELL_TOTAL);
        caret = 0;
        clear_cnt++;
      end
      default: begin
        addr = cell_index(col, rw);
        v.char_code = shadow_char[addr];
        v.attr = shadow_attr[addr];
      end
    endcase
    v.offset = OFFS_W'(caret);
    v.column = COL_IN_W'(caret % SCREEN_W);
    v.row = ROW_IN_W'(caret / SCREEN_W);
    return v;
  endfunction

  // Offer one request beat and record its expected result once accepted
  task automatic send_request(input func_e op, input logic [CHAR_W-1:0] ch,
                              input logic [COL_IN_W-1:0] col, input logic [ROW_IN_W-1:0] rw);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= op;
    req_if.char_code <= ch;
    req_if.column <= col;
    req_if.row <= rw;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    expected_views.push_back(apply_request(op, ch, col, rw));
    requests_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    req_if.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the default attribute while the block is idle
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    attr_now = value;
    attr_writes++;
  endtask

  // Build one random request, biased toward printing and reading back
  task automatic random_request();
    logic [CHAR_W-1:0]   ch;
    logic [COL_IN_W-1:0] col;
    logic [ROW_IN_W-1:0] rw;
    int unsigned         pick;
    int unsigned         sel;
    pick = $urandom_range(99);
    ch = CHAR_W'($urandom_range(255));
    col = COL_IN_W'($urandom_range(127));
    rw = ROW_IN_W'($urandom_range(31));
    if ($urandom_range(1) == 1) begin
      col = COL_IN_W'($urandom_range(SCREEN_W - 1));
      rw = ROW_IN_W'($urandom_range(SCREEN_H - 1));
    end
    if (pick < 56) begin
      sel = $urandom_range(99);
      if (sel < 7) ch = CH_NEWLINE;
      else if (sel < 11) ch = CH_TAB;
      send_request(FUNC_WRITE, ch, col, rw);
    end else if (pick < 70) begin
      send_request(FUNC_SET, ch, col, rw);
    end else if (pick < 97) begin
      // Read back around the cursor row half of the time
      if ($urandom_range(1) == 1) rw = ROW_IN_W'(caret / SCREEN_W);
      send_request(FUNC_READ, ch, col, rw);
    end else begin
      send_request(FUNC_CLEAR, ch, col, rw);
    end
  endtask

  // Reset contents, reset attribute and clamped reads of the corners
  task automatic test_reset_state();
    send_request(FUNC_READ, 8'h00, 7'd0, 5'd0);
    send_request(FUNC_READ, 8'hFF, 7'd127, 5'd31);
    send_request(FUNC_WRITE, 8'h41, 7'd0, 5'd0);
    send_request(FUNC_READ, 8'h00, 7'd0, 5'd0);
  endtask

  // Byte extremes, tab from on and off a stop, newline
  task automatic test_print_controls();
    send_request(FUNC_WRITE, 8'h00, 7'd127, 5'd31);
    send_request(FUNC_WRITE, 8'hFF, 7'd0, 5'd0);
    send_request(FUNC_WRITE, CH_TAB, 7'd0, 5'd0);
    send_request(FUNC_WRITE, CH_TAB, 7'd0, 5'd0);
    send_request(FUNC_WRITE, CH_NEWLINE, 7'd0, 5'd0);
    send_request(FUNC_READ, 8'h00, 7'd2, 5'd0);
  endtask

  // Set cursor with and without clamping; a read leaves the cursor alone
  task automatic test_cursor_moves();
    send_request(FUNC_SET, 8'h00, 7'd127, 5'd31);
    send_request(FUNC_SET, 8'h00, 7'd100, 5'd3);
    send_request(FUNC_SET, 8'h00, 7'd5, 5'd30);
    send_request(FUNC_READ, 8'h00, 7'd1, 5'd0);
    send_request(FUNC_SET, 8'h00, 7'd79, 5'd0);
    send_request(FUNC_WRITE, 8'h7A, 7'd0, 5'd0);
  endtask

  // Run off the end by a character, a newline and a tab
  task automatic test_scroll();
    send_request(FUNC_SET, 8'h00, 7'd78, 5'd24);
    send_request(FUNC_WRITE, 8'h78, 7'd0, 5'd0);
    send_request(FUNC_WRITE, 8'h79, 7'd0, 5'd0);
    send_request(FUNC_READ, 8'h00, 7'd79, 5'd23);
    send_request(FUNC_WRITE, CH_NEWLINE, 7'd0, 5'd0);
    send_request(FUNC_SET, 8'h00, 7'd79, 5'd24);
    send_request(FUNC_WRITE, CH_TAB, 7'd0, 5'd0);
    send_request(FUNC_READ, 8'h00, 7'd79, 5'd22);
  endtask

  // Clear, then print with the attribute at both extremes and blank at the top one
  task automatic test_attribute();
    send_request(FUNC_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(FUNC_READ, 8'h00, 7'd40, 5'd12);
    write_attribute(8'h00);
    send_request(FUNC_WRITE, 8'h61, 7'd0, 5'd0);
    write_attribute(8'hFF);
    send_request(FUNC_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(FUNC_WRITE, 8'h62, 7'd0, 5'd0);
    send_request(FUNC_READ, 8'h00, 7'd1, 5'd0);
  endtask

  // One phase of random traffic at the given idle rates
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_ITEMS) random_request();
    write_attribute(ATTR_W'($urandom_range(255)));
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= hold_req + 1;
    repeat (12) send_request(FUNC_WRITE, CHAR_W'($urandom_range(255)), 7'd0, 5'd0);
    send_request(FUNC_READ, 8'h00, 7'd0, 5'd0);
  endtask

  // Result side: random ready with an optional long hold
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got_view = '{offset: rsp_if.cursor_offset, column: rsp_if.cursor_column,
                   row: rsp_if.cursor_row, char_code: rsp_if.cell_char,
                   attr: rsp_if.cell_attr};
      if (expected_views.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected result beat: offs=%0d col=%0d row=%0d char=%02h attr=%02h",
                   got_view.offset, got_view.column, got_view.row, got_view.char_code,
                   got_view.attr);
      end else begin
        want_view = expected_views.pop_front();
        results_checked++;
        if (got_view !== want_view) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display({"mismatch at result %0d: exp offs=%0d col=%0d row=%0d char=%02h ",
                      "attr=%02h, got offs=%0d col=%0d row=%0d char=%02h attr=%02h"},
                     results_checked, want_view.offset, want_view.column, want_view.row,
                     want_view.char_code, want_view.attr, got_view.offset, got_view.column,
                     got_view.row, got_view.char_code, got_view.attr);
        end
      end
    end
  end

  // Abort if no beat moves for too long
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_views.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_WRITE;
    req_if.char_code = '0;
    req_if.column = '0;
    req_if.row = '0;
    rsp_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    quiet_cycles = 0;
    error_cnt = 0;
    requests_sent = 0;
    results_checked = 0;
    scroll_cnt = 0;
    clear_cnt = 0;
    attr_writes = 0;
    caret = 0;
    attr_now = ATTR_RESET;
    for (int i = 0; i < CELL_TOTAL; i++) begin
      shadow_char[i] = '0;
      shadow_attr[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 68;
    test_reset_state();
    test_print_controls();
    test_cursor_moves();
    test_scroll();
    test_attribute();

    test_random_traffic(19, 68);
    test_random_traffic(68, 19);
    test_random_traffic(0, 0);
    test_backpressure();

    // Drain and let any late beat show up
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests and %0d checked results, with %0d scrolls and %0d clears,",
             requests_sent, results_checked, scroll_cnt, clear_cnt);
    $display("  %0d attribute writes and one long result stall; %0d failures.",
             attr_writes, error_cnt);
    if (error_cnt == 0 && expected_views.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
